// ===== hw/rtl/edh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edh_pkg
// Shared types and constants for the envelope detector with hysteresis.
// ----------------------------------------------------------------------------
package edh_pkg;

  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ENV_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [COEF_W:0]    COEF_ONE       = 17'h10000;
  localparam logic [COEF_W-1:0]  RST_ATTACK     = 16'd59299;
  localparam logic [COEF_W-1:0]  RST_RELEASE    = 16'd59299;
  localparam logic [ENV_W-1:0]   RST_ACT_THR    = 32'd32768;
  localparam logic [ENV_W-1:0]   RST_DEACT_THR  = 32'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK       = 3'd0,
    CFG_RELEASE      = 3'd1,
    CFG_ACT_THR      = 3'd2,
    CFG_DEACT_THR    = 3'd3,
    CFG_COMPLEX      = 3'd4,
    CFG_ACT_MARK_EN  = 3'd5,
    CFG_DEACT_MARK_EN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coeff;
    logic [COEF_W-1:0] release_coeff;
    logic [ENV_W-1:0]  act_thr;
    logic [ENV_W-1:0]  deact_thr;
    logic              complex_mode;
    logic              act_mark_en;
    logic              deact_mark_en;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_SCALE,
    ST_COEF,
    ST_MUL_A,
    ST_MUL_B,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic square;
    logic sum;
    logic root_step;
    logic scale;
    logic coef;
    logic mul_a;
    logic mul_b;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic root_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/edh_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edh_cfg
// Configuration register file, one write per cfg word.
// ----------------------------------------------------------------------------
module edh_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [edh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [edh_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  output edh_pkg::cfg_t                        cfg_o
);
  import edh_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff  <= RST_ATTACK;
      cfg_q.release_coeff <= RST_RELEASE;
      cfg_q.act_thr       <= RST_ACT_THR;
      cfg_q.deact_thr     <= RST_DEACT_THR;
      cfg_q.complex_mode  <= 1'b1;
      cfg_q.act_mark_en   <= 1'b0;
      cfg_q.deact_mark_en <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ATTACK:        cfg_q.attack_coeff  <= cfg_data_i[COEF_W-1:0];
        CFG_RELEASE:       cfg_q.release_coeff <= cfg_data_i[COEF_W-1:0];
        CFG_ACT_THR:       cfg_q.act_thr       <= cfg_data_i[ENV_W-1:0];
        CFG_DEACT_THR:     cfg_q.deact_thr     <= cfg_data_i[ENV_W-1:0];
        CFG_COMPLEX:       cfg_q.complex_mode  <= cfg_data_i[0];
        CFG_ACT_MARK_EN:   cfg_q.act_mark_en   <= cfg_data_i[0];
        CFG_DEACT_MARK_EN: cfg_q.deact_mark_en <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/edh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edh_ctrl
// Sequencer: square, sum, root (complex only), scale, coef, 2 mults, commit.
// ----------------------------------------------------------------------------
module edh_ctrl (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire logic   complex_mode_i,
  input  wire edh_pkg::sts_t sts_i,
  output edh_pkg::cmd_t cmd_o
);
  import edh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = complex_mode_i ? ST_SQUARE : ST_SCALE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        state_d    = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/edh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edh_datapath
// Magnitude (squares + bit-serial root, or |re| in real mode), Q scaling,
// one-pole update, hysteresis flag and output register.
// ----------------------------------------------------------------------------
module edh_datapath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire edh_pkg::cfg_t                 cfg_i,
  input  wire edh_pkg::cmd_t                 cmd_i,
  output edh_pkg::sts_t                      sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [edh_pkg::ENV_W-1:0]          envelope_o,
  output logic                               active_o,
  output logic                               activation_mark_o,
  output logic                               deactivation_mark_o
);
  import edh_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned RW = 2 * SW;
  localparam int unsigned CW = $clog2(SW);
  localparam int unsigned XW = SW + FRAC_BITS;
  localparam int unsigned PW = COEF_W + ENV_W;
  localparam int unsigned AW = PW + 1;

  logic [SW-1:0]     are_q, aim_q;
  logic [RW-1:0]     sq_re_q, sq_im_q;
  logic [RW-1:0]     rad_q;
  logic [SW-1:0]     rem_q;
  logic [SW-1:0]     root_q;
  logic [CW-1:0]     cnt_q;
  logic [ENV_W-1:0]  x_q;
  logic [COEF_W-1:0] coef_q;
  logic [PW-1:0]     p1_q;
  logic [AW-1:0]     acc_q;
  logic [ENV_W-1:0]  env_q;
  logic              active_q;
  logic              out_valid_q;
  logic [ENV_W-1:0]  out_env_q;
  logic              out_act_q, out_am_q, out_dm_q;

  logic [SW-1:0]       are_d, aim_d;
  logic [SW+1:0]       rem_t, trial, rem_sub;
  logic                root_bit;
  logic [SW-1:0]       mag;
  logic [XW+ENV_W-1:0] x_ext;
  logic                x_sat;
  logic [COEF_W:0]     coef_b;
  logic [ENV_W-1:0]    env_new;
  logic                act_set, act_clr, active_d;

  // absolute value; most negative input maps to 2^(SW-1)
  assign are_d = sample_re_i[SW-1] ? (~sample_re_i + 1'b1) : sample_re_i;
  assign aim_d = sample_im_i[SW-1] ? (~sample_im_i + 1'b1) : sample_im_i;

  // one root bit per cycle, radicand consumed two bits at a time
  assign rem_t    = {rem_q, rad_q[RW-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_bit = (rem_t >= trial);
  assign rem_sub  = rem_t - trial;

  assign mag   = cfg_i.complex_mode ? root_q : are_q;
  assign x_ext = {{ENV_W{1'b0}}, mag, {FRAC_BITS{1'b0}}};
  assign x_sat = |x_ext[XW+ENV_W-1:ENV_W];

  assign coef_b  = COEF_ONE - {1'b0, coef_q};
  assign env_new = acc_q[COEF_W +: ENV_W];

  assign act_set  = !active_q && (env_new > cfg_i.act_thr);
  assign act_clr  = active_q && (env_new < cfg_i.deact_thr);
  assign active_d = act_set ? 1'b1 : (act_clr ? 1'b0 : active_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      are_q <= are_d;
      aim_q <= aim_d;
    end
    if (cmd_i.square) begin
      sq_re_q <= are_q * are_q;
      sq_im_q <= aim_q * aim_q;
    end
    if (cmd_i.sum) begin
      rad_q  <= sq_re_q + sq_im_q;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_bit ? rem_sub[SW-1:0] : rem_t[SW-1:0];
      root_q <= {root_q[SW-2:0], root_bit};
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.scale) begin
      x_q <= x_sat ? {ENV_W{1'b1}} : x_ext[ENV_W-1:0];
    end
    if (cmd_i.coef) begin
      coef_q <= (x_q > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
    end
    if (cmd_i.mul_a) begin
      p1_q <= coef_q * env_q;
    end
    if (cmd_i.mul_b) begin
      acc_q <= AW'(p1_q) + coef_b * x_q;
    end
    if (cmd_i.commit) begin
      out_env_q <= env_new;
      out_act_q <= active_d;
      out_am_q  <= act_set & cfg_i.act_mark_en;
      out_dm_q  <= act_clr & cfg_i.deact_mark_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        env_q    <= env_new;
        active_q <= active_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.root_last = (cnt_q == CW'(SW - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign envelope_o          = out_env_q;
  assign active_o            = out_act_q;
  assign activation_mark_o   = out_am_q;
  assign deactivation_mark_o = out_dm_q;

endmodule
`default_nettype wire

// ===== hw/rtl/envelope_detector_hysteresis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// envelope_detector_hysteresis
// Attack/release envelope follower with hysteresis active flag.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one complex or real sample word;
// output channel (out_valid_o/out_ready_i) returns one word per sample: the
// Q16 envelope, the active flag and the activation/deactivation marks.
// cfg channel writes one register per word, index 0..6; cfg_ready_o is
// always high. Write only while no sample is in flight.
// Complex mode runs squares, sum, the bit-serial root, scaling, coefficient
// select, multiplies and commit; real mode skips squares, sum and root.
// The root is formed one bit per cycle. A new sample is taken only in the
// idle state, once the result has entered the output register.
// A stalled receiver holds the finished word; the next sample is accepted
// and processed, then waits in the final step until the word is taken.
// Reset loads the register defaults, clears envelope and active flag.
// ----------------------------------------------------------------------------
module envelope_detector_hysteresis #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_im_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [edh_pkg::ENV_W-1:0]                envelope_o,
  output logic                                     active_o,
  output logic                                     activation_mark_o,
  output logic                                     deactivation_mark_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [edh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [edh_pkg::CFG_DAT_W-1:0]       cfg_data_i
);
  import edh_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  edh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  edh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .complex_mode_i (cfg.complex_mode),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  edh_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_re_i         (sample_re_i),
    .sample_im_i         (sample_im_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .envelope_o          (envelope_o),
    .active_o            (active_o),
    .activation_mark_o   (activation_mark_o),
    .deactivation_mark_o (deactivation_mark_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/edh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edh_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module edh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] envelope_o,
  input wire logic        active_o,
  input wire logic        activation_mark_o,
  input wire logic        deactivation_mark_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(envelope_o) && $stable(active_o))
    else $error("result word changed while stalled");

  a_marks_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(activation_mark_o && deactivation_mark_o))
    else $error("both marks set in one word");

  a_act_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && activation_mark_o |-> active_o)
    else $error("activation mark without active flag");

  a_deact_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deactivation_mark_o |-> !active_o)
    else $error("deactivation mark with active flag");

endmodule

bind envelope_detector_hysteresis edh_checker u_edh_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .envelope_o          (envelope_o),
  .active_o            (active_o),
  .activation_mark_o   (activation_mark_o),
  .deactivation_mark_o (deactivation_mark_o)
);
`default_nettype wire
